// File: rtl/core/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types, codes and memory-map constants of the banked memory bus decoder.
// ----------------------------------------------------------------------------
package bmd_pkg;

    // Video RAM split: switchable tile area, then the fixed map area.
    localparam int VRAM_BANK_BYTES = 6144;
    localparam int WRAM_BANK_BYTES = 4096;
    localparam int VRAM_BYTES      = 8192;

    localparam int TILE_DEPTH   = 2 * VRAM_BANK_BYTES;
    localparam int MAP_DEPTH    = VRAM_BYTES - VRAM_BANK_BYTES;
    localparam int WRAM_BANKS   = 8;
    localparam int WRAM_DEPTH   = WRAM_BANKS * WRAM_BANK_BYTES;
    localparam int SPRITE_DEPTH = 160;
    localparam int HRAM_DEPTH   = 127;

    localparam int VRAM_LOC_W  = $clog2(VRAM_BYTES);
    localparam int TILE_ADDR_W = $clog2(TILE_DEPTH);
    localparam int MAP_ADDR_W  = $clog2(MAP_DEPTH);
    localparam int WRAM_OFS_W  = $clog2(WRAM_BANK_BYTES);
    localparam int WRAM_BANK_W = $clog2(WRAM_BANKS);
    localparam int WRAM_ADDR_W = $clog2(WRAM_DEPTH);
    localparam int SPR_ADDR_W  = $clog2(SPRITE_DEPTH);
    localparam int HRAM_ADDR_W = $clog2(HRAM_DEPTH);

    // Region boundaries
    localparam logic [15:0] ADDR_VRAM     = 16'h8000;
    localparam logic [15:0] ADDR_CRAM     = 16'hA000;
    localparam logic [15:0] ADDR_WRAM     = 16'hC000;
    localparam logic [15:0] ADDR_ECHO     = 16'hE000;
    localparam logic [15:0] ADDR_SPRITE   = 16'hFE00;
    localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
    localparam logic [15:0] ADDR_IO       = 16'hFF00;
    localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;
    localparam logic [15:0] ADDR_BOOT_END = 16'h00FF;
    localparam logic [15:0] ADDR_VBK      = 16'hFF4F;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] ADDR_SVBK     = 16'hFF70;

    localparam logic [7:0] BYTE_BLOCKED = 8'hFF;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_COLOR_MODE = 1'b0;   // word index, paddr[2]

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_BOOT     = 3'd1,
        TGT_CROM     = 3'd2,
        TGT_CRAM     = 3'd3,
        TGT_IO       = 3'd4,
        TGT_IGNORED  = 3'd5
    } target_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_TILE,
        SRC_MAP,
        SRC_WRAM,
        SRC_SPRITE,
        SRC_HRAM
    } rd_src_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  display_mode;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  target;
        logic [15:0] target_offset;
    } rsp_t;

endpackage

// File: rtl/core/bmd_ram.sv
// ----------------------------------------------------------------------------
// bmd_ram
// Single-port synchronous RAM; read data is registered and held between reads.
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/banked_memory_bus_decoder_core.sv
// ----------------------------------------------------------------------------
// banked_memory_bus_decoder_core
// Results: a transaction's result is registered and offered in the cycle after it is accepted.
// Throughput: one transaction per cycle; each store access makes one trip through a
//   single-port RAM, and the request side stalls only while a result waits.
// Reset: rst_n clears the pipeline, vram_bank to 0, wram_bank to 1, the boot
//   flag to 1 and color_mode to 0. RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module banked_memory_bus_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bmd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bmd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,

    // Bus access transactions
    input  logic                            req_valid,
    output logic                            req_ready,
    input  bmd_pkg::req_t                   req,

    // Result transactions
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output bmd_pkg::rsp_t                   rsp
);

    import bmd_pkg::*;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic                   color_mode_reg;
    logic                   vram_bank_reg, vram_bank_next;
    logic [WRAM_BANK_W-1:0] wram_bank_reg, wram_bank_next;
    logic                   boot_enabled_reg, boot_enabled_next;
    logic                   s1_valid_reg, s1_valid_next;

    // Result stage payload
    rd_src_t     s1_src_reg, s1_src_next;
    logic [7:0]  s1_rd_reg, s1_rd_next;
    target_t     s1_target_reg, s1_target_next;
    logic [15:0] s1_offset_reg, s1_offset_next;

    logic req_fire;
    logic cfg_write;

    // RAM ports
    logic                   tile_en, map_en, wram_en, spr_en, hram_en;
    logic [TILE_ADDR_W-1:0] tile_addr;
    logic [MAP_ADDR_W-1:0]  map_addr;
    logic [WRAM_ADDR_W-1:0] wram_addr;
    logic [SPR_ADDR_W-1:0]  spr_addr;
    logic [HRAM_ADDR_W-1:0] hram_addr;
    logic [7:0]             tile_rdata, map_rdata, wram_rdata, spr_rdata, hram_rdata;

    // Video and work RAM local offsets
    logic [VRAM_LOC_W-1:0]  vram_loc;
    logic [VRAM_LOC_W-1:0]  wram_loc;
    logic [WRAM_BANK_W-1:0] wram_sel;

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_COLOR_MODE)
        begin
            prdata[0] = color_mode_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a new transaction unless a finished result is stalled.
    // The RAMs only update their read data on an accepted read, so a
    // stalled result keeps its bytes.
    // ------------------------------------------------------------------
    assign req_ready = !s1_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = s1_valid_reg;

    // Address mapping into the stores
    assign vram_loc = req.address[VRAM_LOC_W-1:0];
    assign wram_loc = req.address[VRAM_LOC_W-1:0];

    always_comb
    begin
        // Upper work RAM half: bank 0 selects bank 1, and without color mode
        // it is always bank 1.
        wram_sel = WRAM_BANK_W'(1);
        if (color_mode_reg && (wram_bank_reg != '0))
        begin
            wram_sel = wram_bank_reg;
        end
    end

    always_comb
    begin
        tile_addr = TILE_ADDR_W'(vram_loc);
        if (color_mode_reg && vram_bank_reg)
        begin
            tile_addr = TILE_ADDR_W'(vram_loc) + TILE_ADDR_W'(VRAM_BANK_BYTES);
        end
        map_addr = MAP_ADDR_W'(vram_loc - VRAM_LOC_W'(VRAM_BANK_BYTES));

        if (wram_loc[WRAM_OFS_W])
        begin
            wram_addr = {wram_sel, wram_loc[WRAM_OFS_W-1:0]};
        end
        else
        begin
            wram_addr = WRAM_ADDR_W'(wram_loc[WRAM_OFS_W-1:0]);
        end

        spr_addr  = req.address[SPR_ADDR_W-1:0];
        hram_addr = req.address[HRAM_ADDR_W-1:0];
    end

    // ------------------------------------------------------------------
    // Decode: pick the region, start the RAM access, and work out what the
    // result stage needs (data source, fixed read value, target, offset).
    // ------------------------------------------------------------------
    always_comb
    begin
        tile_en           = 1'b0;
        map_en            = 1'b0;
        wram_en           = 1'b0;
        spr_en            = 1'b0;
        hram_en           = 1'b0;
        vram_bank_next    = vram_bank_reg;
        wram_bank_next    = wram_bank_reg;
        boot_enabled_next = boot_enabled_reg;
        s1_src_next       = SRC_CONST;
        s1_rd_next        = '0;
        s1_target_next    = TGT_INTERNAL;
        s1_offset_next    = '0;

        if (req.address < ADDR_VRAM)
        begin
            // ROM space: writes are dropped
            if (req.req_type)
            begin
                s1_target_next = TGT_IGNORED;
            end
            else if ((req.address <= ADDR_BOOT_END) && boot_enabled_reg)
            begin
                s1_target_next = TGT_BOOT;
                s1_offset_next = req.address;
            end
            else
            begin
                s1_target_next = TGT_CROM;
                s1_offset_next = req.address;
            end
        end
        else if (req.address < ADDR_CRAM)
        begin
            // Video RAM: reads are blocked in mode 3, writes always land
            if (req.req_type || (req.display_mode != 2'd3))
            begin
                if (vram_loc < VRAM_LOC_W'(VRAM_BANK_BYTES))
                begin
                    tile_en     = 1'b1;
                    s1_src_next = SRC_TILE;
                end
                else
                begin
                    map_en      = 1'b1;
                    s1_src_next = SRC_MAP;
                end
            end
            else
            begin
                s1_rd_next = BYTE_BLOCKED;
            end
            if (req.req_type)
            begin
                s1_src_next = SRC_CONST;
            end
        end
        else if (req.address < ADDR_WRAM)
        begin
            s1_target_next = TGT_CRAM;
            s1_offset_next = req.address - ADDR_CRAM;
        end
        else if (req.address < ADDR_ECHO)
        begin
            wram_en     = 1'b1;
            s1_src_next = req.req_type ? SRC_CONST : SRC_WRAM;
        end
        else if (req.address < ADDR_SPRITE)
        begin
            s1_target_next = TGT_IGNORED;
        end
        else if (req.address < ADDR_UNUSABLE)
        begin
            // Sprite table: reads blocked in modes 2 and 3
            if (req.req_type)
            begin
                spr_en = 1'b1;
            end
            else if (req.display_mode[1])
            begin
                s1_rd_next = BYTE_BLOCKED;
            end
            else
            begin
                spr_en      = 1'b1;
                s1_src_next = SRC_SPRITE;
            end
        end
        else if (req.address < ADDR_IO)
        begin
            s1_target_next = TGT_IGNORED;
        end
        else if (req.address == ADDR_VBK)
        begin
            if (req.req_type)
            begin
                if (color_mode_reg)
                begin
                    vram_bank_next = req.write_data[0];
                end
            end
            else
            begin
                s1_rd_next = {7'h7F, vram_bank_reg};
            end
        end
        else if (req.address == ADDR_BOOT_OFF)
        begin
            if (req.req_type)
            begin
                boot_enabled_next = 1'b0;
            end
        end
        else if (req.address == ADDR_SVBK)
        begin
            if (req.req_type)
            begin
                wram_bank_next = req.write_data[WRAM_BANK_W-1:0];
            end
            else
            begin
                s1_rd_next = 8'(wram_bank_reg);
            end
        end
        else if ((req.address < ADDR_HRAM) || (req.address == ADDR_IE))
        begin
            s1_target_next = TGT_IO;
            s1_offset_next = req.address - ADDR_IO;
        end
        else
        begin
            hram_en     = 1'b1;
            s1_src_next = req.req_type ? SRC_CONST : SRC_HRAM;
        end
    end

    // Advance the result stage on accept, drop it once taken
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= 1'b0;
            vram_bank_reg    <= 1'b0;
            wram_bank_reg    <= WRAM_BANK_W'(1);
            boot_enabled_reg <= 1'b1;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_write && (paddr[2] == REG_COLOR_MODE))
            begin
                color_mode_reg <= pwdata[0];
            end
            if (req_fire)
            begin
                vram_bank_reg    <= vram_bank_next;
                wram_bank_reg    <= wram_bank_next;
                boot_enabled_reg <= boot_enabled_next;
            end
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_src_reg    <= s1_src_next;
            s1_rd_reg     <= s1_rd_next;
            s1_target_reg <= s1_target_next;
            s1_offset_reg <= s1_offset_next;
        end
    end

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    bmd_ram #(.WIDTH(8), .DEPTH(TILE_DEPTH)) u_tile_ram (
        .clk   (clk),
        .en    (req_fire && tile_en),
        .we    (req.req_type),
        .addr  (tile_addr),
        .wdata (req.write_data),
        .rdata (tile_rdata)
    );

    bmd_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .en    (req_fire && map_en),
        .we    (req.req_type),
        .addr  (map_addr),
        .wdata (req.write_data),
        .rdata (map_rdata)
    );

    bmd_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
        .clk   (clk),
        .en    (req_fire && wram_en),
        .we    (req.req_type),
        .addr  (wram_addr),
        .wdata (req.write_data),
        .rdata (wram_rdata)
    );

    bmd_ram #(.WIDTH(8), .DEPTH(SPRITE_DEPTH)) u_sprite_ram (
        .clk   (clk),
        .en    (req_fire && spr_en),
        .we    (req.req_type),
        .addr  (spr_addr),
        .wdata (req.write_data),
        .rdata (spr_rdata)
    );

    bmd_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
        .clk   (clk),
        .en    (req_fire && hram_en),
        .we    (req.req_type),
        .addr  (hram_addr),
        .wdata (req.write_data),
        .rdata (hram_rdata)
    );

    // ------------------------------------------------------------------
    // Result: pick the RAM byte or the fixed value chosen at decode
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp.target        = s1_target_reg;
        rsp.target_offset = s1_offset_reg;
        case (s1_src_reg)
            SRC_TILE:   rsp.read_data = tile_rdata;
            SRC_MAP:    rsp.read_data = map_rdata;
            SRC_WRAM:   rsp.read_data = wram_rdata;
            SRC_SPRITE: rsp.read_data = spr_rdata;
            SRC_HRAM:   rsp.read_data = hram_rdata;
            default:    rsp.read_data = s1_rd_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !rsp_ready) |-> !req_ready)
        else $error("request taken while a result is stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid)
        else $error("accepted transaction produced no result");

    a_boot_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_enabled_reg |=> !boot_enabled_reg)
        else $error("boot flag set again after disable");

    a_forward_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.target != TGT_INTERNAL)) |-> (rsp.read_data == '0))
        else $error("forwarded transaction returned data");

    a_banks_move_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> ($stable(wram_bank_reg) && $stable(vram_bank_reg)))
        else $error("bank register changed without a transaction");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp))
        else $error("stalled result changed");

endmodule

// File: dv/bmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_checker
// Watches the configuration port and both transaction channels of the banked
// memory bus decoder, keeps its own copy of the memory map and the bank
// registers, and checks every result against the predicted one in order.
// ----------------------------------------------------------------------------
module bmd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bmd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bmd_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  bmd_pkg::req_t                  req,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  bmd_pkg::rsp_t                  rsp,
    input  logic                           end_of_test,
    output int                             fail_count
);

    import bmd_pkg::*;

    logic [7:0] tile_bytes [TILE_DEPTH];
    logic [7:0] map_bytes  [MAP_DEPTH];
    logic [7:0] wram_bytes [WRAM_DEPTH];
    logic [7:0] oam_bytes  [SPRITE_DEPTH];
    logic [7:0] hram_bytes [HRAM_DEPTH];

    logic       vbank_sel;
    logic [2:0] wbank_sel;
    logic       boot_on;
    logic       color_on;

    rsp_t pending_results[$];
    rsp_t want;
    int   mismatches = 0;
    int   results_seen = 0;
    bit   leftovers_checked = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] wanted);
        $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                 $time, results_seen, what, got, wanted);
        mismatches++;
    endtask

    // Apply one bus access to the shadow state and work out its result.
    function automatic rsp_t decode_access(req_t a);
        rsp_t       r;
        int         loc;
        int         idx;
        logic [2:0] bank;
        r = '0;
        r.target = TGT_INTERNAL;
        if (a.address < ADDR_VRAM)
        begin
            if (a.req_type)
            begin
                r.target = TGT_IGNORED;
            end
            else if (a.address <= ADDR_BOOT_END && boot_on)
            begin
                r.target        = TGT_BOOT;
                r.target_offset = a.address;
            end
            else
            begin
                r.target        = TGT_CROM;
                r.target_offset = a.address;
            end
        end
        else if (a.address < ADDR_CRAM)
        begin
            loc = a.address - ADDR_VRAM;
            if (loc < VRAM_BANK_BYTES)
            begin
                idx = (color_on && vbank_sel) ? VRAM_BANK_BYTES + loc : loc;
                if (a.req_type)
                    tile_bytes[idx] = a.write_data;
                else
                    r.read_data = (a.display_mode == 2'd3) ? BYTE_BLOCKED
                                                           : tile_bytes[idx];
            end
            else
            begin
                idx = loc - VRAM_BANK_BYTES;
                if (a.req_type)
                    map_bytes[idx] = a.write_data;
                else
                    r.read_data = (a.display_mode == 2'd3) ? BYTE_BLOCKED
                                                           : map_bytes[idx];
            end
        end
        else if (a.address < ADDR_WRAM)
        begin
            r.target        = TGT_CRAM;
            r.target_offset = a.address - ADDR_CRAM;
        end
        else if (a.address < ADDR_ECHO)
        begin
            loc = a.address - ADDR_WRAM;
            if (loc < WRAM_BANK_BYTES)
            begin
                idx = loc;
            end
            else
            begin
                bank = (color_on && wbank_sel != 3'd0) ? wbank_sel : 3'd1;
                idx  = int'(bank) * WRAM_BANK_BYTES + (loc % WRAM_BANK_BYTES);
            end
            if (a.req_type)
                wram_bytes[idx] = a.write_data;
            else
                r.read_data = wram_bytes[idx];
        end
        else if (a.address < ADDR_SPRITE)
        begin
            r.target = TGT_IGNORED;
        end
        else if (a.address < ADDR_UNUSABLE)
        begin
            idx = a.address - ADDR_SPRITE;
            if (a.req_type)
                oam_bytes[idx] = a.write_data;
            else
                r.read_data = (a.display_mode >= 2'd2) ? BYTE_BLOCKED : oam_bytes[idx];
        end
        else if (a.address < ADDR_IO)
        begin
            r.target = TGT_IGNORED;
        end
        else if (a.address == ADDR_VBK)
        begin
            if (!a.req_type)
                r.read_data = {7'h7F, vbank_sel};
            else if (color_on)
                vbank_sel = a.write_data[0];
        end
        else if (a.address == ADDR_BOOT_OFF)
        begin
            if (a.req_type)
                boot_on = 1'b0;
        end
        else if (a.address == ADDR_SVBK)
        begin
            if (a.req_type)
                wbank_sel = a.write_data[2:0];
            else
                r.read_data = {5'd0, wbank_sel};
        end
        else if (a.address < ADDR_HRAM || a.address == ADDR_IE)
        begin
            r.target        = TGT_IO;
            r.target_offset = a.address - ADDR_IO;
        end
        else
        begin
            idx = a.address - ADDR_HRAM;
            if (a.req_type)
                hram_bytes[idx] = a.write_data;
            else
                r.read_data = hram_bytes[idx];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            vbank_sel = 1'b0;
            wbank_sel = 3'd1;
            boot_on   = 1'b1;
            color_on  = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_COLOR_MODE)
                color_on = pwdata[0];
            // Queue first: an access accepted now cannot answer in this cycle.
            if (req_valid && req_ready)
                pending_results.push_back(decode_access(req));
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, target", 16'(rsp.target), 16'h0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", 16'(rsp.read_data), 16'(want.read_data));
                    if (rsp.target !== want.target)
                        report_mismatch("target", 16'(rsp.target), 16'(want.target));
                    if (rsp.target_offset !== want.target_offset)
                        report_mismatch("target_offset", rsp.target_offset,
                                        want.target_offset);
                end
            end
            if (end_of_test && !leftovers_checked)
            begin
                leftovers_checked = 1;
                if (pending_results.size() != 0)
                    report_mismatch("results never returned, count",
                                    16'(pending_results.size()), 16'h0);
            end
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bus access transactions into the banked memory bus decoder: a short
// directed walk through every region and control register, then random phases
// over both color-mode settings with sender gaps and receiver stalls. A side
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bmd_pkg::*;

    localparam bit ACC_READ  = 1'b0;
    localparam bit ACC_WRITE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] COLOR_MODE_ADDR = {REG_COLOR_MODE, 2'b00};

    // Flat numbering of every storage byte, used to track which were written.
    localparam int SLOT_MAP   = TILE_DEPTH;
    localparam int SLOT_WRAM  = SLOT_MAP + MAP_DEPTH;
    localparam int SLOT_OAM   = SLOT_WRAM + WRAM_DEPTH;
    localparam int SLOT_HRAM  = SLOT_OAM + SPRITE_DEPTH;
    localparam int SLOT_TOTAL = SLOT_HRAM + HRAM_DEPTH;

    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 345;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RECENT_MAX      = 48;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  end_of_test;
    int                    fail_count;

    // Stimulus-side view of the bank state, needed to keep reads on written bytes.
    bit         written [SLOT_TOTAL];
    bit         color_sel;
    bit         vbank_sel;
    logic [2:0] wbank_sel;
    logic [15:0] recent_addrs[$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    bit hold_kick;
    int accepted;
    int returned;
    int n_reads;
    int n_writes;
    int n_store_reads;

    banked_memory_bus_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bmd_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .end_of_test (end_of_test),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count transactions on both channels at the sampling edge.
    initial
    begin
        accepted = 0;
        returned = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                accepted++;
            if (rsp_valid && rsp_ready)
                returned++;
        end
    end

    // Result side: random stalls, plus a long hold-off on request so the block
    // backs up and has to stall its request side.
    initial
    begin
        rsp_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_kick)
            begin
                hold_kick = 0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run if it ever stops making progress.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles: %0d transactions sent, %0d results back",
                 CYCLE_LIMIT, accepted, returned);
        $display("TB_ERROR");
        $finish;
    end

    // Map an address to its storage byte under the current banking, or -1.
    function automatic int slot_of(logic [15:0] addr);
        int         loc;
        logic [2:0] bank;
        if (addr >= ADDR_VRAM && addr < ADDR_CRAM)
        begin
            loc = addr - ADDR_VRAM;
            if (loc >= VRAM_BANK_BYTES)
                return SLOT_MAP + loc - VRAM_BANK_BYTES;
            return (color_sel && vbank_sel) ? VRAM_BANK_BYTES + loc : loc;
        end
        if (addr >= ADDR_WRAM && addr < ADDR_ECHO)
        begin
            loc = addr - ADDR_WRAM;
            if (loc < WRAM_BANK_BYTES)
                return SLOT_WRAM + loc;
            bank = (color_sel && wbank_sel != 3'd0) ? wbank_sel : 3'd1;
            return SLOT_WRAM + int'(bank) * WRAM_BANK_BYTES + (loc % WRAM_BANK_BYTES);
        end
        if (addr >= ADDR_SPRITE && addr < ADDR_UNUSABLE)
            return SLOT_OAM + (addr - ADDR_SPRITE);
        if (addr >= ADDR_HRAM && addr < ADDR_IE)
            return SLOT_HRAM + (addr - ADDR_HRAM);
        return -1;
    endfunction

    // Offer one transaction: optional idle gap, then hold valid until accepted.
    task automatic send_access(req_t a);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= a;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
    endtask

    // Track written bytes and bank registers, then send. A read of a byte that
    // was never written turns into a write of that byte.
    task automatic issue(bit wr, logic [15:0] addr, logic [7:0] data, logic [1:0] mode);
        int   slot;
        req_t a;
        slot = slot_of(addr);
        if (!wr && slot >= 0 && !written[slot])
            wr = ACC_WRITE;
        if (wr)
        begin
            n_writes++;
            if (slot >= 0)
            begin
                written[slot] = 1;
                recent_addrs.push_back(addr);
                if (recent_addrs.size() > RECENT_MAX)
                    void'(recent_addrs.pop_front());
            end
            if (addr == ADDR_VBK && color_sel)
                vbank_sel = data[0];
            if (addr == ADDR_SVBK)
                wbank_sel = data[2:0];
        end
        else
        begin
            n_reads++;
            if (slot >= 0)
                n_store_reads++;
        end
        a.req_type     = wr;
        a.address      = addr;
        a.write_data   = data;
        a.display_mode = mode;
        send_access(a);
    endtask

    // Drop valid and wait until every accepted transaction has its result.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (returned != accepted)
            @(negedge clk);
    endtask

    task automatic write_color_mode(bit value);
        wait_drained();
        repeat (2) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_MODE_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        color_sel = value;
    endtask

    // Random access: mostly stored bytes (fresh or revisited), some bank
    // register traffic, the rest anywhere in the 64K map.
    task automatic random_access();
        int          pick;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 35 || (pick < 65 && recent_addrs.size() == 0))
        begin
            case ($urandom_range(0, 3))
                0:       addr = ADDR_VRAM + 16'($urandom_range(0, VRAM_BYTES - 1));
                1:       addr = ADDR_WRAM + 16'($urandom_range(0, 2 * WRAM_BANK_BYTES - 1));
                2:       addr = ADDR_SPRITE + 16'($urandom_range(0, SPRITE_DEPTH - 1));
                default: addr = ADDR_HRAM + 16'($urandom_range(0, HRAM_DEPTH - 1));
            endcase
        end
        else if (pick < 65)
        begin
            addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        end
        else if (pick < 78)
        begin
            case ($urandom_range(0, 2))
                0:       addr = ADDR_VBK;
                1:       addr = ADDR_SVBK;
                default: addr = ADDR_BOOT_OFF;
            endcase
        end
        else
        begin
            addr = 16'($urandom);
        end
        issue(1'($urandom), addr, 8'($urandom), 2'($urandom));
    endtask

    int phase_idle  [NUM_PHASES] = '{0, 52, 0, 18, 0};
    int phase_stall [NUM_PHASES] = '{0, 0, 52, 18, 0};
    bit phase_color [NUM_PHASES] = '{1, 0, 1, 0, 1};

    initial
    begin
        // Hold every input at a known value from time zero.
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        req         = '0;
        end_of_test = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_kick   = 0;
        color_sel   = 1'b0;
        vbank_sel   = 1'b0;
        wbank_sel   = 3'd1;
        n_reads       = 0;
        n_writes      = 0;
        n_store_reads = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_color_mode(1'b0);

        // Directed walk: boot window while enabled, ROM writes dropped, blocked
        // video and sprite reads, echo and unusable space, forwarded I/O and IE,
        // the last high RAM byte, the bank registers at reset, then boot disable.
        issue(ACC_READ,  16'h0000,      8'h00, 2'd0);
        issue(ACC_READ,  ADDR_BOOT_END, 8'h00, 2'd1);
        issue(ACC_READ,  16'h0100,      8'h00, 2'd2);
        issue(ACC_WRITE, 16'h7FFF,      8'h55, 2'd3);
        issue(ACC_WRITE, ADDR_VRAM,     8'hFF, 2'd3);
        issue(ACC_READ,  ADDR_VRAM,     8'h00, 2'd0);
        issue(ACC_READ,  ADDR_VRAM,     8'h00, 2'd3);
        issue(ACC_READ,  ADDR_CRAM,     8'h00, 2'd0);
        issue(ACC_WRITE, 16'hBFFF,      8'h12, 2'd1);
        issue(ACC_WRITE, 16'hDFFF,      8'hA5, 2'd2);
        issue(ACC_READ,  16'hDFFF,      8'h00, 2'd1);
        issue(ACC_READ,  ADDR_ECHO,     8'h00, 2'd0);
        issue(ACC_WRITE, 16'hFEFF,      8'h00, 2'd0);
        issue(ACC_WRITE, 16'hFE9F,      8'h3C, 2'd3);
        issue(ACC_READ,  16'hFE9F,      8'h00, 2'd1);
        issue(ACC_READ,  16'hFE9F,      8'h00, 2'd2);
        issue(ACC_READ,  ADDR_IO,       8'h00, 2'd0);
        issue(ACC_WRITE, ADDR_IE,       8'h1F, 2'd0);
        issue(ACC_WRITE, 16'hFFFE,      8'h81, 2'd2);
        issue(ACC_READ,  16'hFFFE,      8'h00, 2'd3);
        issue(ACC_READ,  ADDR_VBK,      8'h00, 2'd0);
        issue(ACC_WRITE, ADDR_VBK,      8'h01, 2'd0);
        issue(ACC_READ,  ADDR_SVBK,     8'h00, 2'd0);
        issue(ACC_READ,  ADDR_BOOT_OFF, 8'h00, 2'd0);
        issue(ACC_WRITE, ADDR_BOOT_OFF, 8'h00, 2'd0);
        issue(ACC_READ,  16'h0000,      8'h00, 2'd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_color_mode(phase_color[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Starve the result side for a while; keep offering requests.
                if (p == 0 && i == 100)
                    hold_kick = 1;
                // Stop offering until the block has answered everything.
                if (p == 2 && i == 170)
                    wait_drained();
                random_access();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        end_of_test <= 1'b1;
        @(posedge clk);
        @(negedge clk);

        $display("Covered %0d bus transactions (%0d reads, %0d writes) in %0d phases,",
                 accepted, n_reads, n_writes, NUM_PHASES + 1);
        $display("both color settings, %0d reads of stored bytes, one %0d-cycle result hold-off.",
                 n_store_reads, HOLD_OFF_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bmd_pkg.sv
rtl/core/bmd_ram.sv
rtl/core/banked_memory_bus_decoder_core.sv
dv/bmd_checker.sv
dv/tb.sv
